>>> rtl/fcss_pkg.sv
`timescale 1ns / 1ps
// Shared types, constants and the control program of the font cell size selector.
package fcss_pkg;

	localparam int MAX_CELLS_DEF = 32;

	// Field widths.
	localparam int KIND_W     = 2;
	localparam int SEL_W      = 8;
	localparam int DIM_W      = 8;
	localparam int TWIPS_W    = 15;
	localparam int OUT_SEL_W  = 11;
	localparam int SCH_W      = 8;
	localparam int PX_W       = 12;
	localparam int CFG_IDX_W  = 2;
	localparam int CFG_DATA_W = 12;

	typedef enum logic [KIND_W-1:0] {
		KIND_CLEAR = 2'd0,
		KIND_LOAD  = 2'd1,
		KIND_QUERY = 2'd2
	} kind_t;

	typedef enum logic [CFG_IDX_W-1:0] {
		REG_SYS_CELL_HEIGHT = 2'd0,
		REG_PIXEL_WIDTH     = 2'd1,
		REG_PIXEL_HEIGHT    = 2'd2
	} cfg_reg_t;

	localparam logic [SCH_W-1:0] SCH_RESET = 8'd0;
	localparam logic [PX_W-1:0]  PXW_RESET = 12'd372;
	localparam logic [PX_W-1:0]  PXH_RESET = 12'd372;

	// Arithmetic constants.
	localparam int ASPECT_MIN_10   = 16;
	localparam int ASPECT_MAX_10   = 30;
	localparam int REFERENCE_TWIPS = 240;
	localparam int TWIPS_TO_UM_NUM = 635;
	localparam int TWIPS_TO_UM_DEN = 36;
	localparam int TWIPS_PER_POINT = 20;

	// Divider: dividend up to 635 * 32767, divisor up to 36 * 4095.
	localparam int DIV_NW = 25;
	localparam int DIV_DW = 18;
	localparam int DIV_CW = $clog2(DIV_NW);

	// Target height is clamped to 1..256; every stored height is below the top.
	localparam int TGT_W   = 9;
	localparam int TGT_MAX = 256;
	localparam int DELTA_W = 8;
	localparam int PROD_W  = DIM_W + PX_W;
	localparam int ASP_W   = PROD_W + 5;

	typedef struct packed {
		logic start;
		logic step;
	} div_ctl_t;

	localparam int STEP_W = 3;

	typedef enum logic [STEP_W-1:0] {
		ST_IDLE  = 3'd0,
		ST_PREP  = 3'd1,
		ST_DIV   = 3'd2,
		ST_TGT   = 3'd3,
		ST_SCAN  = 3'd4,
		ST_DRAIN = 3'd5,
		ST_PASS  = 3'd6,
		ST_OUT   = 3'd7
	} step_t;

	typedef enum logic [2:0] {
		C_NEVER      = 3'd0,
		C_NO_QUERY   = 3'd1,
		C_DIV_MORE   = 3'd2,
		C_EMPTY      = 3'd3,
		C_SCAN_MORE  = 3'd4,
		C_PIPE_BUSY  = 3'd5,
		C_PASS_AGAIN = 3'd6,
		C_OUT_BUSY   = 3'd7
	} cond_t;

	typedef struct packed {
		logic  accept;
		logic  prep;
		logic  div_step;
		logic  tgt;
		logic  scan;
		logic  pass_next;
		logic  out_ld;
		cond_t cond;
		step_t target;
	} ucode_t;

	// One control word per step. When the condition holds the sequencer jumps to
	// the target, otherwise it moves to the next step; the last step wraps to idle.
	function automatic ucode_t ucode_rom(step_t step);
		ucode_t uc;
		uc        = '0;
		uc.cond   = C_NEVER;
		uc.target = ST_IDLE;
		case (step)
			ST_IDLE: begin
				uc.accept = 1'b1;
				uc.cond   = C_NO_QUERY;
				uc.target = ST_IDLE;
			end
			ST_PREP: begin
				uc.prep = 1'b1;
			end
			ST_DIV: begin
				uc.div_step = 1'b1;
				uc.cond     = C_DIV_MORE;
				uc.target   = ST_DIV;
			end
			ST_TGT: begin
				uc.tgt    = 1'b1;
				uc.cond   = C_EMPTY;
				uc.target = ST_OUT;
			end
			ST_SCAN: begin
				uc.scan   = 1'b1;
				uc.cond   = C_SCAN_MORE;
				uc.target = ST_SCAN;
			end
			ST_DRAIN: begin
				uc.cond   = C_PIPE_BUSY;
				uc.target = ST_DRAIN;
			end
			ST_PASS: begin
				uc.pass_next = 1'b1;
				uc.cond      = C_PASS_AGAIN;
				uc.target    = ST_SCAN;
			end
			ST_OUT: begin
				uc.out_ld = 1'b1;
				uc.cond   = C_OUT_BUSY;
				uc.target = ST_OUT;
			end
			default: begin
				uc = '0;
			end
		endcase
		return uc;
	endfunction

endpackage

>>> rtl/fcss_req_if.sv
`timescale 1ns / 1ps
// Input item channel of the font cell size selector.
interface fcss_req_if import fcss_pkg::*; ();
	logic               valid;
	logic               ready;
	logic [KIND_W-1:0]  kind;
	logic [SEL_W-1:0]   entry_select;
	logic [DIM_W-1:0]   entry_width;
	logic [DIM_W-1:0]   entry_height;
	logic [TWIPS_W-1:0] requested_twips;

	modport source (
		output valid, kind, entry_select, entry_width, entry_height, requested_twips,
		input  ready
	);
	modport sink (
		input  valid, kind, entry_select, entry_width, entry_height, requested_twips,
		output ready
	);
endinterface

>>> rtl/fcss_rsp_if.sv
`timescale 1ns / 1ps
// Result item channel of the font cell size selector.
interface fcss_rsp_if import fcss_pkg::*; ();
	logic                 valid;
	logic                 ready;
	logic [OUT_SEL_W-1:0] chosen_select;
	logic                 aspect_matched;
	logic                 used_fallback;

	modport source (
		output valid, chosen_select, aspect_matched, used_fallback,
		input  ready
	);
	modport sink (
		input  valid, chosen_select, aspect_matched, used_fallback,
		output ready
	);
endinterface

>>> rtl/fcss_ram.sv
`timescale 1ns / 1ps
// Generic single-write, single-read RAM with registered read data.
module fcss_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 32,
	localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
	input  logic             clk,
	input  logic             we,
	input  logic [AW-1:0]    waddr,
	input  logic [WIDTH-1:0] wdata,
	input  logic [AW-1:0]    raddr,
	output logic [WIDTH-1:0] rdata
);
	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rdata <= mem[raddr];
	end
endmodule

>>> rtl/fcss_div.sv
`timescale 1ns / 1ps
// Restoring divider that produces one quotient bit per cycle while ctl.step is high.
module fcss_div import fcss_pkg::*; (
	input  logic              clk,
	input  logic              arst_n,
	input  div_ctl_t          ctl,
	input  logic [DIV_NW-1:0] num,
	input  logic [DIV_DW-1:0] den,
	output logic [DIV_NW-1:0] quot,
	output logic              more
);
	logic [DIV_CW-1:0] cnt_q;
	logic [DIV_NW-1:0] acc_q;
	logic [DIV_DW-1:0] rem_q;
	logic [DIV_DW-1:0] den_q;
	logic [DIV_DW:0]   shifted;
	logic [DIV_DW+1:0] diff;
	logic              borrow;

	assign shifted = {rem_q, acc_q[DIV_NW-1]};
	assign diff    = {1'b0, shifted} - {2'b00, den_q};
	assign borrow  = diff[DIV_DW+1];
	assign quot    = acc_q;
	assign more    = cnt_q != DIV_CW'(DIV_NW - 1);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q <= '0;
		end else if (ctl.start) begin
			cnt_q <= '0;
		end else if (ctl.step) begin
			cnt_q <= cnt_q + DIV_CW'(1);
		end
	end

	// The dividend shifts out at the top while quotient bits enter at the bottom.
	always_ff @(posedge clk) begin
		if (ctl.start) begin
			acc_q <= num;
			rem_q <= '0;
			den_q <= den;
		end else if (ctl.step) begin
			acc_q <= {acc_q[DIV_NW-2:0], ~borrow};
			rem_q <= borrow ? shifted[DIV_DW-1:0] : diff[DIV_DW-1:0];
		end
	end
endmodule

>>> rtl/font_cell_size_selector_unit.sv
`timescale 1ns / 1ps
// Top level of the font cell size selector: cell table, query sequencer and datapath.
// Clear and load items are handled in the idle step. A query runs the 25-step divider,
// then goes straight to the output when the table is empty, or else scans the stored
// cells, one cell per cycle, in one or two passes before the result is loaded.
// A new query can be taken in the cycle in which the previous result appears at the output.
// Reset empties the table, loads the register defaults and leaves the output empty.
module font_cell_size_selector_unit import fcss_pkg::*; #(
	parameter int MAX_CELLS = MAX_CELLS_DEF
) (
	input  logic                  clk,
	input  logic                  arst_n,
	fcss_req_if.sink              req,
	fcss_rsp_if.source            rsp,
	input  logic                  cfg_we,
	input  logic [CFG_IDX_W-1:0]  cfg_index,
	input  logic [CFG_DATA_W-1:0] cfg_data
);
	localparam int AW = (MAX_CELLS > 1) ? $clog2(MAX_CELLS) : 1;
	localparam int CW = $clog2(MAX_CELLS + 1);
	localparam int RAM_W = SEL_W + 2 * DIM_W;

	// Configuration registers.
	logic [SCH_W-1:0] sch_q;
	logic [PX_W-1:0]  pxw_q;
	logic [PX_W-1:0]  pxh_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			sch_q <= SCH_RESET;
			pxw_q <= PXW_RESET;
			pxh_q <= PXH_RESET;
		end else if (cfg_we) begin
			case (cfg_index)
				REG_SYS_CELL_HEIGHT: sch_q <= cfg_data[SCH_W-1:0];
				REG_PIXEL_WIDTH:     pxw_q <= cfg_data;
				REG_PIXEL_HEIGHT:    pxh_q <= cfg_data;
				default: ;
			endcase
		end
	end

	// Sequencer.
	step_t  pc_q, pc_d;
	ucode_t uc;
	logic   jump;
	logic   accepted;
	logic   query_in;
	logic   out_busy;
	logic   scan_more;
	logic   pipe_busy;
	logic   empty;
	logic   div_more;

	logic [CW-1:0] entry_count_q;
	logic [AW-1:0] idx_q;
	logic          pass_q;
	logic          found_q;
	logic          v_s1, v_s2;
	logic          out_valid_q;

	assign accepted  = req.valid && req.ready;
	assign query_in  = accepted && (req.kind == KIND_QUERY);
	assign out_busy  = out_valid_q && !rsp.ready;
	assign scan_more = (CW'(idx_q) + CW'(1)) < entry_count_q;
	assign pipe_busy = v_s1 || v_s2;
	assign empty     = entry_count_q == '0;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pc_q <= ST_IDLE;
		end else begin
			pc_q <= pc_d;
		end
	end

	always_comb begin
		uc = ucode_rom(pc_q);
		case (uc.cond)
			C_NEVER:      jump = 1'b0;
			C_NO_QUERY:   jump = !query_in;
			C_DIV_MORE:   jump = div_more;
			C_EMPTY:      jump = empty;
			C_SCAN_MORE:  jump = scan_more;
			C_PIPE_BUSY:  jump = pipe_busy;
			C_PASS_AGAIN: jump = !found_q && !pass_q;
			C_OUT_BUSY:   jump = out_busy;
			default:      jump = 1'b0;
		endcase
		pc_d = jump ? uc.target : step_t'(pc_q + STEP_W'(1));
	end

	assign req.ready = uc.accept;

	// Cell table.
	logic [DIM_W-1:0] last_w_q, last_h_q;
	logic             last_valid_q;
	logic             load_ok, do_load, do_clear;
	logic [RAM_W-1:0] rd_data;

	assign load_ok = (entry_count_q < CW'(MAX_CELLS))
		&& !(last_valid_q && req.entry_width == last_w_q && req.entry_height == last_h_q)
		&& (req.entry_width != '0) && (req.entry_height != '0);
	assign do_load  = accepted && (req.kind == KIND_LOAD) && load_ok;
	assign do_clear = accepted && (req.kind == KIND_CLEAR);

	fcss_ram #(
		.WIDTH(RAM_W),
		.DEPTH(MAX_CELLS)
	) u_cells (
		.clk  (clk),
		.we   (do_load),
		.waddr(entry_count_q[AW-1:0]),
		.wdata({req.entry_select, req.entry_width, req.entry_height}),
		.raddr(idx_q),
		.rdata(rd_data)
	);

	// Divider operands: the two truncating divisions of the pixel path fold into one.
	logic [TWIPS_W-1:0] twips_q;
	logic [DIV_NW-1:0]  div_num;
	logic [DIV_DW-1:0]  div_den;
	logic [DIV_NW-1:0]  quot;
	logic [PX_W-1:0]    pxh_eff;
	div_ctl_t           div_ctl;

	assign pxh_eff = (pxh_q == '0) ? PX_W'(1) : pxh_q;

	always_comb begin
		if (empty) begin
			div_num = DIV_NW'(twips_q);
			div_den = DIV_DW'(TWIPS_PER_POINT);
		end else if (sch_q != '0) begin
			div_num = DIV_NW'(sch_q) * DIV_NW'(twips_q);
			div_den = DIV_DW'(REFERENCE_TWIPS);
		end else begin
			div_num = DIV_NW'(twips_q) * DIV_NW'(TWIPS_TO_UM_NUM);
			div_den = DIV_DW'(pxh_eff) * DIV_DW'(TWIPS_TO_UM_DEN);
		end
	end

	assign div_ctl.start = uc.prep;
	assign div_ctl.step  = uc.div_step;

	fcss_div u_div (
		.clk   (clk),
		.arst_n(arst_n),
		.ctl   (div_ctl),
		.num   (div_num),
		.den   (div_den),
		.quot  (quot),
		.more  (div_more)
	);

	// Scan datapath: RAM read, products and distance, then aspect test and best update.
	logic [TGT_W-1:0]   tgt_q;
	logic [SEL_W-1:0]   rd_sel;
	logic [DIM_W-1:0]   rd_w, rd_h;
	logic [TGT_W-1:0]   h_ext;
	logic [TGT_W-1:0]   h_delta;
	logic [PROD_W-1:0]  pw_s2, ph_s2;
	logic [DELTA_W-1:0] d_s2;
	logic [SEL_W-1:0]   sel_s2;
	logic [ASP_W-1:0]   ph10, pw_lo, pw_hi;
	logic               aspect_ok, consider, better;
	logic [DELTA_W-1:0] best_d_q;
	logic [SEL_W-1:0]   best_sel_q;
	logic               best_match_q;

	assign {rd_sel, rd_w, rd_h} = rd_data;
	assign h_ext   = TGT_W'(rd_h);
	assign h_delta = (h_ext >= tgt_q) ? (h_ext - tgt_q) : (tgt_q - h_ext);

	always_ff @(posedge clk) begin
		pw_s2  <= PROD_W'(rd_w) * PROD_W'(pxw_q);
		ph_s2  <= PROD_W'(rd_h) * PROD_W'(pxh_q);
		d_s2   <= h_delta[DELTA_W-1:0];
		sel_s2 <= rd_sel;
	end

	assign ph10      = ASP_W'(ph_s2) * ASP_W'(10);
	assign pw_lo     = ASP_W'(pw_s2) * ASP_W'(ASPECT_MIN_10);
	assign pw_hi     = ASP_W'(pw_s2) * ASP_W'(ASPECT_MAX_10);
	assign aspect_ok = (ph10 >= pw_lo) && (ph10 <= pw_hi);
	assign consider  = v_s2 && (pass_q || aspect_ok);
	// Strictly nearer only, so the earlier cell keeps a tie.
	assign better    = !found_q || (d_s2 < best_d_q);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			entry_count_q <= '0;
			last_valid_q  <= 1'b0;
			idx_q         <= '0;
			pass_q        <= 1'b0;
			found_q       <= 1'b0;
			v_s1          <= 1'b0;
			v_s2          <= 1'b0;
		end else begin
			v_s1 <= uc.scan;
			v_s2 <= v_s1;
			if (do_clear) begin
				entry_count_q <= '0;
				last_valid_q  <= 1'b0;
			end else if (do_load) begin
				entry_count_q <= entry_count_q + CW'(1);
				last_valid_q  <= 1'b1;
			end
			if (uc.tgt) begin
				idx_q   <= '0;
				pass_q  <= 1'b0;
				found_q <= 1'b0;
			end else if (uc.scan) begin
				idx_q <= idx_q + AW'(1);
			end else if (uc.pass_next) begin
				idx_q  <= '0;
				pass_q <= 1'b1;
			end
			if (consider && better) begin
				found_q <= 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (do_load) begin
			last_w_q <= req.entry_width;
			last_h_q <= req.entry_height;
		end
		if (query_in) begin
			twips_q <= req.requested_twips;
		end
		if (uc.tgt) begin
			if (quot == '0) begin
				tgt_q <= TGT_W'(1);
			end else if (quot > DIV_NW'(TGT_MAX)) begin
				tgt_q <= TGT_W'(TGT_MAX);
			end else begin
				tgt_q <= quot[TGT_W-1:0];
			end
		end
		if (consider && better) begin
			best_d_q     <= d_s2;
			best_sel_q   <= sel_s2;
			best_match_q <= !pass_q;
		end
	end

	// Output register.
	logic                 out_ld;
	logic [OUT_SEL_W-1:0] chosen_q;
	logic                 matched_q;
	logic                 fallback_q;

	assign out_ld = uc.out_ld && !out_busy;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (out_ld) begin
			out_valid_q <= 1'b1;
		end else if (rsp.ready) begin
			out_valid_q <= 1'b0;
		end
	end

	// With an empty table the quotient is twips/20, which fits the output width.
	always_ff @(posedge clk) begin
		if (out_ld) begin
			if (empty) begin
				chosen_q  <= (quot == '0) ? OUT_SEL_W'(1) : quot[OUT_SEL_W-1:0];
				matched_q <= 1'b0;
			end else begin
				chosen_q  <= (best_sel_q == '0) ? OUT_SEL_W'(1) : OUT_SEL_W'(best_sel_q);
				matched_q <= best_match_q;
			end
			fallback_q <= empty;
		end
	end

	assign rsp.valid          = out_valid_q;
	assign rsp.chosen_select  = chosen_q;
	assign rsp.aspect_matched = matched_q;
	assign rsp.used_fallback  = fallback_q;

	assert property (@(posedge clk) disable iff (!arst_n)
		entry_count_q <= CW'(MAX_CELLS))
		else $error("cell table count exceeds capacity");

	assert property (@(posedge clk) disable iff (!arst_n)
		(pc_q == ST_PASS && pass_q) |-> found_q)
		else $error("second scan pass ended without a chosen cell");

	assert property (@(posedge clk) disable iff (!arst_n)
		v_s2 |-> (pc_q == ST_SCAN || pc_q == ST_DRAIN))
		else $error("scan pipeline active outside a table scan");

	assert property (@(posedge clk) disable iff (!arst_n)
		pc_q == ST_SCAN |-> !empty)
		else $error("table scan started on an empty table");

	assert property (@(posedge clk) disable iff (!arst_n)
		rsp.valid |-> !(rsp.used_fallback && rsp.aspect_matched))
		else $error("fallback result marked as aspect matched");
endmodule
